/* hdl/clns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_pkg: shared types, codes and step tables
// Request codes, the classified command word, the pin step word and the
// fixed power-up tables of the 4-bit LCD bus sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  // Request codes
  localparam logic [2:0] OpInit   = 3'd0;
  localparam logic [2:0] OpCmd    = 3'd1;
  localparam logic [2:0] OpChar   = 3'd2;
  localparam logic [2:0] OpCursor = 3'd3;
  localparam logic [2:0] OpClear  = 3'd4;

  // Command queue geometry
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Power-up preamble
  localparam int unsigned PreSteps  = 9;
  localparam int unsigned PreIdxW   = 4;
  localparam logic [PreIdxW-1:0] PreLastIdx = PreIdxW'(PreSteps - 1);
  localparam logic [2:0] InitLastByte = 3'd4;

  // Hold times in ms
  localparam logic [3:0] HoldShort = 4'd3;
  localparam logic [3:0] HoldLong  = 4'd6;
  localparam logic [3:0] HoldPulse = 4'd1;
  localparam logic [3:0] HoldNone  = 4'd0;

  // Classified request, as handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    logic [3:0] tail_hold;
  } clns_cmd_t;

  // Position inside a request
  typedef struct packed {
    logic               in_pre;
    logic [PreIdxW-1:0] pre_idx;
    logic [2:0]         byte_idx;
    logic [1:0]         phase;
  } clns_pos_t;

  // One pin step
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic [3:0] hold;
    logic       last;
  } clns_step_t;

  // Preamble step table: {en, nibble, hold}
  function automatic logic [8:0] clns_pre(input logic [PreIdxW-1:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = {1'b0, 4'd0, 4'd15};
      4'd1:    r = {1'b1, 4'd3, 4'd1};
      4'd2:    r = {1'b0, 4'd3, 4'd4};
      4'd3:    r = {1'b1, 4'd3, 4'd1};
      4'd4:    r = {1'b0, 4'd3, 4'd1};
      4'd5:    r = {1'b1, 4'd3, 4'd1};
      4'd6:    r = {1'b0, 4'd3, 4'd1};
      4'd7:    r = {1'b1, 4'd2, 4'd1};
      4'd8:    r = {1'b0, 4'd2, 4'd3};
      default: r = {1'b0, 4'd0, 4'd0};
    endcase
    return r;
  endfunction

  // Instruction bytes sent after the preamble
  function automatic logic [7:0] clns_init_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h28;
      3'd1:    r = 8'h08;
      3'd2:    r = 8'h01;
      3'd3:    r = 8'h03;
      3'd4:    r = 8'h0C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Start position of a request
  function automatic clns_pos_t clns_start(input clns_cmd_t cmd);
    clns_pos_t p;
    p.in_pre   = cmd.is_init;
    p.pre_idx  = '0;
    p.byte_idx = '0;
    p.phase    = '0;
    return p;
  endfunction

  // Pin step at a given position
  function automatic clns_step_t clns_step(input clns_cmd_t cmd, input clns_pos_t pos);
    clns_step_t s;
    logic [8:0] pre;
    logic [7:0] b;
    logic [3:0] tail;
    logic       fin;
    pre  = clns_pre(pos.pre_idx);
    b    = cmd.is_init ? clns_init_byte(pos.byte_idx) : cmd.data;
    tail = cmd.is_init ? HoldLong : cmd.tail_hold;
    fin  = !cmd.is_init || (pos.byte_idx == InitLastByte);
    s.rs = cmd.is_init ? 1'b0 : cmd.rs;
    if (pos.in_pre) begin
      s.en   = pre[8];
      s.nib  = pre[7:4];
      s.hold = pre[3:0];
      s.last = 1'b0;
    end else begin
      s.en   = !pos.phase[0];
      s.nib  = pos.phase[1] ? b[3:0] : b[7:4];
      case (pos.phase)
        2'd0:    s.hold = HoldPulse;
        2'd1:    s.hold = HoldNone;
        2'd2:    s.hold = HoldPulse;
        default: s.hold = tail;
      endcase
      s.last = (pos.phase == 2'd3) && fin;
    end
    return s;
  endfunction

  // Position after the given one (meaningless after the last step)
  function automatic clns_pos_t clns_next(input clns_pos_t pos);
    clns_pos_t n;
    n = pos;
    if (pos.in_pre) begin
      if (pos.pre_idx == PreLastIdx) begin
        n.in_pre   = 1'b0;
        n.byte_idx = '0;
        n.phase    = '0;
      end else begin
        n.pre_idx = pos.pre_idx + 1'b1;
      end
    end else if (pos.phase == 2'd3) begin
      n.byte_idx = pos.byte_idx + 1'b1;
      n.phase    = '0;
    end else begin
      n.phase = pos.phase + 1'b1;
    end
    return n;
  endfunction

endpackage

/* hdl/clns_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_front: request intake and classification
// Registers one request, turns it into a command word and drops unknown codes.
// ----------------------------------------------------------------------------
module clns_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        value_i,
  input  logic [1:0]        row_i,
  input  logic [5:0]        column_i,
  output logic              cmd_valid_o,
  output clns_pkg::clns_cmd_t cmd_o,
  input  logic              cmd_full_i
);
  import clns_pkg::*;

  logic      valid_q, valid_d;
  clns_cmd_t cmd_q, cmd_d;
  logic      known;
  logic      handoff;
  logic      take;
  logic [7:0] pos;

  assign handoff = valid_q && !cmd_full_i;
  assign full    = valid_q && cmd_full_i;
  assign take    = push && !full;

  always_comb begin
    pos = 8'h80;
    if (row_i == 2'd2) begin
      pos = pos | 8'h40;
    end
    if (column_i[5:4] == 2'b00) begin
      pos = pos | {4'b0000, column_i[3:0]};
    end
  end

  always_comb begin
    known             = 1'b1;
    cmd_d.is_init     = 1'b0;
    cmd_d.rs          = 1'b0;
    cmd_d.data        = value_i;
    cmd_d.tail_hold   = HoldShort;
    case (operation_i)
      OpInit: begin
        cmd_d.is_init   = 1'b1;
        cmd_d.tail_hold = HoldLong;
      end
      OpCmd: begin
        cmd_d.rs = 1'b0;
      end
      OpChar: begin
        cmd_d.rs = 1'b1;
      end
      OpCursor: begin
        cmd_d.data = pos;
      end
      OpClear: begin
        cmd_d.data      = 8'h01;
        cmd_d.tail_hold = HoldLong;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (handoff) begin
      valid_d = 1'b0;
    end
    if (take && known) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && known) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* hdl/clns_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_queue: command queue
// Short first-in first-out store of command words between front and back.
// ----------------------------------------------------------------------------
module clns_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  clns_pkg::clns_cmd_t wr_data_i,
  output logic                full_o,
  input  logic                rd_i,
  output clns_pkg::clns_cmd_t rd_data_o,
  output logic                empty_o
);
  import clns_pkg::*;

  clns_cmd_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/clns_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_back: pin step generator
// Walks each command word through its pin steps into an output register, one
// step a cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module clns_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_empty_i,
  input  clns_pkg::clns_cmd_t  cmd_i,
  output logic                 cmd_rd_o,
  output logic                 empty,
  input  logic                 pop,
  output clns_pkg::clns_step_t step_o
);
  import clns_pkg::*;

  logic       busy_q, busy_d;
  clns_cmd_t  cur_q;
  clns_pos_t  pos_q;
  clns_cmd_t  src_cmd;
  clns_pos_t  src_pos;
  clns_step_t step;
  logic       have;
  logic       fire;
  logic       out_valid_q;
  clns_step_t out_q;

  // Start a fresh command straight from the queue head when idle
  assign src_cmd  = busy_q ? cur_q : cmd_i;
  assign src_pos  = busy_q ? pos_q : clns_start(cmd_i);
  assign have     = busy_q || !cmd_empty_i;
  assign step     = clns_step(src_cmd, src_pos);
  assign fire     = have && (!out_valid_q || pop);
  assign cmd_rd_o = fire && !busy_q;

  always_comb begin
    busy_d = busy_q;
    if (fire) begin
      busy_d = !step.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cur_q <= src_cmd;
      pos_q <= clns_next(src_pos);
      out_q <= step;
    end
  end

  assign empty  = !out_valid_q;
  assign step_o = out_q;

endmodule

/* hdl/char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer: 4-bit character-LCD bus step sequencer
// Turns LCD requests (init, command, character, set cursor, clear) into the
// list of pin steps that drive a 4-bit character-LCD bus.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: present operation_i, value_i, row_i
//   and column_i with push high; the word is taken at a clock edge where
//   full is low. Unknown operation codes are taken and dropped.
//   Step side is a queue read port: while empty is low the oldest pin step
//   sits on reg_select_o, enable_o, nibble_o, hold_ms_o and last_o; pulse
//   pop to take it. last_o marks the final step of a request.
//   Each byte request yields 4 steps, one per cycle while pop keeps up, and
//   requests run back to back; init yields 29 steps. The rate is set by the
//   step generator, which emits one step per cycle unless pop stalls it.
//   The first step of a request passes the intake register, then the
//   command queue, then the step register, before it shows up.
//   A 4-deep command queue sits between intake and generator, so intake
//   keeps taking requests while the generator works or is stalled.
//   When pop stays low the step register holds, the generator stops, and the
//   queue fills until full rises. Reset empties every stage; no step is
//   pending after reset. Holding the pins for hold_ms is left to the user.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation_i,
  input  logic [7:0] value_i,
  input  logic [1:0] row_i,
  input  logic [5:0] column_i,
  output logic       empty,
  input  logic       pop,
  output logic       reg_select_o,
  output logic       enable_o,
  output logic [3:0] nibble_o,
  output logic [3:0] hold_ms_o,
  output logic       last_o
);
  import clns_pkg::*;

  // Intake -> queue
  logic       front_valid;
  clns_cmd_t  front_cmd;
  logic       q_full;
  // Queue -> generator
  logic       q_empty;
  clns_cmd_t  q_cmd;
  logic       q_rd;
  // Step register
  clns_step_t step;

  // Classify requests and hold one in the intake register
  clns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .value_i     (value_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_full_i  (q_full)
  );

  // Decouple intake from the generator
  clns_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_cmd),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_cmd),
    .empty_o   (q_empty)
  );

  // Advance through the pin steps of each command
  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_cmd),
    .cmd_rd_o    (q_rd),
    .empty       (empty),
    .pop         (pop),
    .step_o      (step)
  );

  assign reg_select_o = step.rs;
  assign enable_o     = step.en;
  assign nibble_o     = step.nib;
  assign hold_ms_o    = step.hold;
  assign last_o       = step.last;

endmodule
